@@ rtl/kvt_pkg.sv @@
// package for the bounded key/value table
// operation codes, command struct, sequencer states and default sizes
// no dependencies
package kvt_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;
  localparam int CMP_W          = 16;

  localparam logic [8:0] CAP_RESET = 9'd256;

  // func codes on the request channel
  localparam logic [2:0] FN_INSERT = 3'd0;
  localparam logic [2:0] FN_UPDATE = 3'd1;
  localparam logic [2:0] FN_UPSERT = 3'd2;
  localparam logic [2:0] FN_ERASE  = 3'd3;
  localparam logic [2:0] FN_LOOKUP = 3'd4;
  localparam logic [2:0] FN_READ   = 3'd5;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_UPDATE,
    OP_UPSERT,
    OP_ERASE,
    OP_LOOKUP,
    OP_READ,
    OP_BAD
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_SHIFT
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] key;
    logic [31:0] value;
    logic [7:0]  index;
  } cmd_t;

endpackage

@@ rtl/kvt_if.sv @@
// valid/ready channel interfaces for the request and response sides
// depends on nothing
interface kvt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] key;
  logic [31:0] value;
  logic [7:0]  index;
  modport source (output valid, func, key, value, index, input ready);
  modport sink (input valid, func, key, value, index, output ready);
endinterface

interface kvt_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] out_key;
  logic [31:0] out_value;
  logic [8:0]  entry_count;
  logic        is_empty;
  modport source (output valid, ok, out_key, out_value, entry_count, is_empty, input ready);
  modport sink (input valid, ok, out_key, out_value, entry_count, is_empty, output ready);
endinterface

@@ rtl/bounded_key_value_table.sv @@
// top level of the bounded key/value table
// depends on kvt_pkg, kvt_if, kvt_front and kvt_back
//
// channel   dir   signals                                         handshake
// req       in    func, key, value, index                          valid/ready
// rsp       out   ok, out_key, out_value, entry_count, is_empty    valid/ready
// cfg       in    cfg_we, cfg_data (capacity_limit)                write enable
//
// one transaction at a time in the back end; the front queue holds two more
// read at index passes through the READ state; unknown func or an empty table answers from idle
// key operations scan one entry per cycle over the memory read port
// erase then moves each later entry down, one per cycle
// synchronous reset clears count, queue and response valid; no memory clearing pass
// a stalled response holds the back end; the queue keeps taking requests until full
module bounded_key_value_table
  import kvt_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  kvt_in_if.sink     req,
  kvt_out_if.source  rsp,
  input  logic       cfg_we,
  input  logic [8:0] cfg_data
);

  // capacity limit register
  logic [8:0] cap;
  logic       cmd_valid;
  logic       cmd_pop;
  cmd_t       cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_we) begin
      cap <= cfg_data;
    end
  end

  // decode and queue
  kvt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // memories and sequencer
  kvt_back #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cap       (cap),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .rsp       (rsp)
  );

  // a command is only taken from a non-empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // no command is taken while a response is still pending
  a_pop_free: assert property (@(posedge clk) disable iff (rst) cmd_pop |-> !rsp.valid)
    else $error("command popped while response pending");

  // no response right after reset
  a_rst_quiet: assert property (@(posedge clk) $past(rst) |-> !rsp.valid)
    else $error("response valid after reset");

endmodule

@@ rtl/kvt_front.sv @@
// front end: accepts request transactions, decodes func, two-entry command queue
// depends on kvt_pkg and kvt_if
module kvt_front
  import kvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  kvt_in_if.sink     req,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_pop
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  op_t        op_dec;

  always_comb begin
    case (req.func)
      FN_INSERT: op_dec = OP_INSERT;
      FN_UPDATE: op_dec = OP_UPDATE;
      FN_UPSERT: op_dec = OP_UPSERT;
      FN_ERASE:  op_dec = OP_ERASE;
      FN_LOOKUP: op_dec = OP_LOOKUP;
      FN_READ:   op_dec = OP_READ;
      default:   op_dec = OP_BAD;
    endcase
  end

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{op: op_dec, key: req.key, value: req.value, index: req.index};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (cmd_pop) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

@@ rtl/kvt_back.sv @@
// back end: entry memories, scan/shift sequencer and response register
// depends on kvt_pkg and kvt_if
module kvt_back
  import kvt_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [8:0] cap,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  kvt_out_if.source  rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [KEY_BITS-1:0]   key_mem [DEPTH];
  logic [VALUE_BITS-1:0] val_mem [DEPTH];
  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;

  state_t  state, state_next;
  cmd_t    cur;
  cmd_t    act;
  logic [AW-1:0] ptr, ptr_next;
  logic [CW-1:0] count, count_next;

  logic                  res_valid;
  logic                  res_ok;
  logic [31:0]           res_key;
  logic [31:0]           res_val;

  logic                  go, hit, more, room, idx_ok, is_ins;
  logic                  rd_en, kwe, vwe;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [VALUE_BITS-1:0] wr_val;
  logic                  fin, fin_ok;
  logic [31:0]           fin_key, fin_val;

  assign go      = (state == ST_IDLE) && cmd_valid && !res_valid;
  assign cmd_pop = go;
  assign act     = (state == ST_IDLE) ? cmd : cur;
  assign hit     = (key_rd == KEY_BITS'(cur.key));
  assign more    = (CMP_W'(ptr) + CMP_W'(1)) < CMP_W'(count);
  assign room    = (CMP_W'(count) < CMP_W'(cap)) && (CMP_W'(count) < CMP_W'(DEPTH));
  assign idx_ok  = CMP_W'(cmd.index) < CMP_W'(count);
  assign is_ins  = (act.op == OP_INSERT) || (act.op == OP_UPSERT);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (go) begin
          if (cmd.op == OP_READ) begin
            if (idx_ok) state_next = ST_READ;
          end else if (cmd.op != OP_BAD && count != '0) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_READ: state_next = ST_IDLE;
      ST_SCAN: begin
        if (hit) state_next = (cur.op == OP_ERASE && more) ? ST_SHIFT : ST_IDLE;
        else if (!more) state_next = ST_IDLE;
      end
      ST_SHIFT: begin
        if (!more) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = ptr + AW'(1);
    kwe        = 1'b0;
    vwe        = 1'b0;
    wr_addr    = AW'(count);
    wr_key     = KEY_BITS'(act.key);
    wr_val     = VALUE_BITS'(act.value);
    fin        = 1'b0;
    fin_ok     = 1'b0;
    fin_key    = '0;
    fin_val    = '0;
    ptr_next   = ptr;
    count_next = count;
    case (state)
      ST_IDLE: begin
        if (go) begin
          if (cmd.op == OP_READ) begin
            if (idx_ok) begin
              rd_en    = 1'b1;
              rd_addr  = AW'(cmd.index);
              ptr_next = AW'(cmd.index);
            end else begin
              fin = 1'b1;
            end
          end else if (cmd.op == OP_BAD) begin
            fin = 1'b1;
          end else if (count == '0) begin
            fin = 1'b1;
            if (is_ins && room) begin
              kwe        = 1'b1;
              vwe        = 1'b1;
              fin_ok     = 1'b1;
              count_next = count + CW'(1);
            end
          end else begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            ptr_next = '0;
          end
        end
      end
      ST_READ: begin
        fin     = 1'b1;
        fin_ok  = 1'b1;
        fin_key = 32'(key_rd);
        fin_val = 32'(val_rd);
      end
      ST_SCAN: begin
        if (hit) begin
          case (cur.op)
            OP_UPDATE, OP_UPSERT: begin
              vwe     = 1'b1;
              wr_addr = ptr;
              fin     = 1'b1;
              fin_ok  = 1'b1;
            end
            OP_LOOKUP: begin
              fin     = 1'b1;
              fin_ok  = 1'b1;
              fin_val = 32'(val_rd);
            end
            OP_ERASE: begin
              if (more) begin
                rd_en    = 1'b1;
                ptr_next = ptr + AW'(1);
              end else begin
                fin        = 1'b1;
                fin_ok     = 1'b1;
                count_next = count - CW'(1);
              end
            end
            default: fin = 1'b1;
          endcase
        end else if (more) begin
          rd_en    = 1'b1;
          ptr_next = ptr + AW'(1);
        end else begin
          // key absent: insert or upsert adds it at the tail if there is room
          fin = 1'b1;
          if (is_ins && room) begin
            kwe        = 1'b1;
            vwe        = 1'b1;
            fin_ok     = 1'b1;
            count_next = count + CW'(1);
          end
        end
      end
      ST_SHIFT: begin
        kwe     = 1'b1;
        vwe     = 1'b1;
        wr_addr = ptr - AW'(1);
        wr_key  = key_rd;
        wr_val  = val_rd;
        if (more) begin
          rd_en    = 1'b1;
          ptr_next = ptr + AW'(1);
        end else begin
          fin        = 1'b1;
          fin_ok     = 1'b1;
          count_next = count - CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (kwe) key_mem[wr_addr] <= wr_key;
    if (vwe) val_mem[wr_addr] <= wr_val;
    if (rd_en) begin
      key_rd <= key_mem[rd_addr];
      val_rd <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (go) cur <= cmd;
    ptr <= ptr_next;
    if (fin) begin
      res_ok  <= fin_ok;
      res_key <= fin_key;
      res_val <= fin_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (fin) res_valid <= 1'b1;
      else if (rsp.ready) res_valid <= 1'b0;
    end
  end

  assign rsp.valid       = res_valid;
  assign rsp.ok          = res_ok;
  assign rsp.out_key     = res_key;
  assign rsp.out_value   = res_val;
  assign rsp.entry_count = 9'(count);
  assign rsp.is_empty    = (count == '0);

endmodule

@@ bench/kvt_table_checker.sv @@
`timescale 1ns / 1ps
// checker for the bounded key/value table: watches request, response and config
// depends on kvt_pkg and the kvt_in_if / kvt_out_if channel interfaces
module kvt_table_checker
  import kvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  kvt_in_if          req,
  kvt_out_if         rsp,
  input  logic       cfg_we,
  input  logic [8:0] cfg_data,
  output int         err_count,
  output int         pending
);

  typedef struct packed {
    logic        ok;
    logic [31:0] out_key;
    logic [31:0] out_value;
    logic [8:0]  entry_count;
    logic        is_empty;
  } table_result_t;

  logic [31:0]   shadow_keys [256];
  logic [31:0]   shadow_vals [256];
  int unsigned   shadow_count;
  logic [8:0]    shadow_cap;
  table_result_t expected_results[$];

  initial begin
    err_count = 0;
    pending   = 0;
  end

  function automatic int find_entry(input logic [31:0] k);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_keys[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic logic try_insert(input logic [31:0] k, input logic [31:0] v);
    int unsigned lim;
    lim = (shadow_cap < 9'd256) ? shadow_cap : 256;
    if (find_entry(k) >= 0 || shadow_count >= lim) return 1'b0;
    shadow_keys[shadow_count] = k;
    shadow_vals[shadow_count] = v;
    shadow_count++;
    return 1'b1;
  endfunction

  function automatic table_result_t table_apply(input logic [2:0] fn, input logic [31:0] k,
                                                input logic [31:0] v, input logic [7:0] idx);
    table_result_t r;
    int p;
    r = '0;
    p = find_entry(k);
    case (fn)
      FN_INSERT: r.ok = try_insert(k, v);
      FN_UPDATE, FN_UPSERT: begin
        if (p >= 0) begin
          shadow_vals[p] = v;
          r.ok = 1'b1;
        end else if (fn == FN_UPSERT) begin
          r.ok = try_insert(k, v);
        end
      end
      FN_ERASE: begin
        if (p >= 0) begin
          for (int z = p; z + 1 < shadow_count; z++) begin
            shadow_keys[z] = shadow_keys[z + 1];
            shadow_vals[z] = shadow_vals[z + 1];
          end
          shadow_count--;
          r.ok = 1'b1;
        end
      end
      FN_LOOKUP: begin
        if (p >= 0) begin
          r.ok = 1'b1;
          r.out_value = shadow_vals[p];
        end
      end
      FN_READ: begin
        if (idx < shadow_count) begin
          r.ok = 1'b1;
          r.out_key = shadow_keys[idx];
          r.out_value = shadow_vals[idx];
        end
      end
      default: ;
    endcase
    r.entry_count = shadow_count[8:0];
    r.is_empty = (shadow_count == 0);
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
    $display("mismatch on %s: expected %0h, got %0h at %0t", what, exp_v, got_v, $realtime);
    err_count++;
  endtask

  always @(posedge clk) begin
    table_result_t e;
    if (rst) begin
      shadow_count = 0;
      shadow_cap = CAP_RESET;
      expected_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected response", 32'd0, 32'd1);
        end else begin
          e = expected_results.pop_front();
          if (rsp.ok !== e.ok) report("ok", 32'(e.ok), 32'(rsp.ok));
          if (rsp.out_key !== e.out_key) report("out_key", e.out_key, rsp.out_key);
          if (rsp.out_value !== e.out_value) report("out_value", e.out_value, rsp.out_value);
          if (rsp.entry_count !== e.entry_count)
            report("entry_count", 32'(e.entry_count), 32'(rsp.entry_count));
          if (rsp.is_empty !== e.is_empty)
            report("is_empty", 32'(e.is_empty), 32'(rsp.is_empty));
        end
      end
      if (req.valid && req.ready)
        expected_results.push_back(table_apply(req.func, req.key, req.value, req.index));
      if (cfg_we) shadow_cap = cfg_data;
    end
    pending = expected_results.size();
  end

endmodule

@@ bench/tb_bounded_key_value_table.sv @@
`timescale 1ns / 1ps
// top of the key/value table bench: clock, reset, stimulus and verdict
// depends on kvt_pkg, the channel interfaces, the block and kvt_table_checker
module tb_bounded_key_value_table;
  import kvt_pkg::*;

  // worst case is an erase on a full table plus stalls
  localparam int CYCLE_LIMIT = 4_000_000;

  // func codes with no operation behind them
  localparam logic [2:0] FN_UNUSED_LO = 3'd6;
  localparam logic [2:0] FN_UNUSED_HI = 3'd7;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [8:0] cfg_data;
  int         err_count;
  int         pending;
  int         cycles;
  int         send_idle_pct;
  int         recv_idle_pct;
  logic [31:0] key_pool [24];
  logic [31:0] fill_keys [256];

  kvt_in_if  req ();
  kvt_out_if rsp ();

  bounded_key_value_table dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  kvt_table_checker chk (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .err_count (err_count),
    .pending   (pending)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run guard: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver side: random back-pressure, changed on the falling edge
  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one request transaction; valid stays high across back-to-back items
  task automatic send(input logic [2:0] fn, input logic [31:0] k,
                      input logic [31:0] v, input logic [7:0] idx);
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.func  <= fn;
    req.key   <= k;
    req.value <= v;
    req.index <= idx;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending until every expected response is back, then let things settle
  task automatic drain_responses();
    req.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // capacity write, only while the table is idle
  task automatic set_capacity(input logic [8:0] cap);
    drain_responses();
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // random item: mostly keys from a small pool so hits, duplicates and erases happen
  task automatic send_random();
    int          w;
    logic [2:0]  fn;
    logic [31:0] k;
    logic [7:0]  idx;
    w = $urandom_range(99);
    if (w < 25) fn = FN_INSERT;
    else if (w < 40) fn = FN_UPSERT;
    else if (w < 52) fn = FN_UPDATE;
    else if (w < 70) fn = FN_ERASE;
    else if (w < 85) fn = FN_LOOKUP;
    else if (w < 97) fn = FN_READ;
    else fn = ($urandom_range(1) == 0) ? FN_UNUSED_LO : FN_UNUSED_HI;
    k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(23)] : $urandom;
    idx = ($urandom_range(99) < 10) ? 8'($urandom_range(255)) : 8'($urandom_range(30));
    send(fn, k, $urandom, idx);
  endtask

  initial begin
    logic [8:0]  caps [6];
    logic [31:0] tmp;
    int          j;
    caps = '{9'd5, 9'd511, 9'd0, 9'd17, 9'd1, 9'd40};
    cycles = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.func = '0;
    req.key = '0;
    req.value = '0;
    req.index = '0;
    rsp.ready = 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 80;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty-table cases, extremes of key and value, every operation
    send(FN_READ,   32'h0, 32'h0, 8'd0);
    send(FN_LOOKUP, 32'h0, 32'h0, 8'd0);
    send(FN_ERASE,  32'h1234, 32'h0, 8'd0);
    send(FN_UPDATE, 32'h1234, 32'h55, 8'd0);
    send(FN_INSERT, 32'h0, 32'h0, 8'd0);
    send(FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
    send(FN_INSERT, 32'h0, 32'hDEAD, 8'd0);           // duplicate key refused
    send(FN_UPSERT, 32'h0, 32'hA5A5_A5A5, 8'd0);      // upsert of existing key
    send(FN_UPSERT, 32'h5A5A_5A5A, 32'h1, 8'd0);      // upsert of new key
    send(FN_UPDATE, 32'hFFFF_FFFF, 32'h8000_0000, 8'd0);
    send(FN_LOOKUP, 32'hFFFF_FFFF, 32'h0, 8'd0);
    send(FN_READ,   32'h0, 32'h0, 8'd2);
    send(FN_READ,   32'h0, 32'h0, 8'd255);            // index out of range
    send(FN_UNUSED_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send(FN_UNUSED_HI, 32'h0, 32'h0, 8'd0);
    send(FN_ERASE,  32'hFFFF_FFFF, 32'h0, 8'd0);      // middle erase, later entry shifts
    send(FN_READ,   32'h0, 32'h0, 8'd1);
    send(FN_ERASE,  32'h0, 32'h0, 8'd0);
    send(FN_READ,   32'h0, 32'h0, 8'd0);

    // full table at a small capacity, then capacity lowered below the count
    set_capacity(9'd2);
    send(FN_INSERT, 32'h77, 32'h7, 8'd0);
    send(FN_INSERT, 32'h78, 32'h8, 8'd0);             // refused, table full
    send(FN_UPSERT, 32'h79, 32'h9, 8'd0);             // absent key, refused
    set_capacity(9'd1);
    send(FN_INSERT, 32'h7A, 32'hA, 8'd0);
    send(FN_ERASE,  32'h77, 32'h0, 8'd0);
    set_capacity(9'd0);
    send(FN_INSERT, 32'h7B, 32'hB, 8'd0);

    // fill the whole table at full capacity, one over refused
    set_capacity(9'd256);
    foreach (fill_keys[i]) fill_keys[i] = {23'($urandom_range(32'h7F_FFFF)), 1'b1, 8'(i)};
    send(FN_ERASE, 32'h5A5A_5A5A, 32'h0, 8'd0);       // start from an empty table
    foreach (fill_keys[i]) send(FN_INSERT, fill_keys[i], $urandom, 8'd0);
    send(FN_INSERT, 32'h0, 32'h0, 8'd0);
    send(FN_READ, 32'h0, 32'h0, 8'd255);
    send(FN_LOOKUP, fill_keys[200], 32'h0, 8'd0);
    send(FN_UPDATE, fill_keys[255], 32'hC0FFEE, 8'd0);
    set_capacity(9'd3);                               // far below the count
    send(FN_INSERT, 32'h1, 32'h1, 8'd0);

    // empty it again in shuffled order
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = fill_keys[i];
      fill_keys[i] = fill_keys[j];
      fill_keys[j] = tmp;
    end
    foreach (fill_keys[i]) send(FN_ERASE, fill_keys[i], 32'h0, 8'd0);

    // random phases across capacity settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      set_capacity(caps[ph]);
      if (ph < 2) begin
        send_idle_pct = 18;
        recv_idle_pct = 80;
      end else if (ph < 4) begin
        send_idle_pct = 80;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (150) send_random();
    end

    drain_responses();
    repeat (20) @(negedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
